[src/iesc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the infix expression syntax checker.
package iesc_pkg;

  localparam int MaxLength  = 255;
  localparam int QueueDepth = 2;

  // Class of the last complete token.
  typedef enum logic [3:0] {
    CLS_START   = 4'd0,
    CLS_SIGN    = 4'd1,
    CLS_OPEN    = 4'd2,
    CLS_CLOSE   = 4'd3,
    CLS_MULDIV  = 4'd4,
    CLS_POWER   = 4'd5,
    CLS_MOD     = 4'd6,
    CLS_OPERAND = 4'd7,
    CLS_FUNC    = 4'd8
  } class_t;

  // Which previous classes allow a given token, one bit per class code.
  localparam logic [15:0] SignOkSet      = 16'h008D;
  localparam logic [15:0] OpenOkSet      = 16'h0177;
  localparam logic [15:0] AfterOperandSet = 16'h0088;
  localparam logic [15:0] OperandOkSet   = 16'h0077;
  localparam logic [15:0] EndBadSet      = 16'h0176;

  // Character kinds found by the front end.
  typedef enum logic [4:0] {
    K_SPACE,
    K_SIGN,
    K_OPEN,
    K_CLOSE,
    K_MULDIV,
    K_POWER,
    K_DIGIT,
    K_DOT,
    K_EXP,
    K_M,
    K_A,
    K_S,
    K_C,
    K_T,
    K_L,
    K_X,
    K_OTHER
  } kind_t;

  // Number and word in progress.
  typedef enum logic [4:0] {
    P_NONE      = 5'd0,
    P_INT       = 5'd1,
    P_DOT0      = 5'd2,
    P_FRAC      = 5'd3,
    P_E         = 5'd4,
    P_ESIGN     = 5'd5,
    P_EXP       = 5'd6,
    P_A         = 5'd8,
    P_AC        = 5'd9,
    P_ACO       = 5'd10,
    P_AS        = 5'd11,
    P_ASI       = 5'd12,
    P_AT        = 5'd13,
    P_ATA       = 5'd14,
    P_S         = 5'd15,
    P_SI        = 5'd16,
    P_SQ        = 5'd17,
    P_SQR       = 5'd18,
    P_C         = 5'd19,
    P_CO        = 5'd20,
    P_T         = 5'd21,
    P_TA        = 5'd22,
    P_L         = 5'd23,
    P_LO        = 5'd24,
    P_M         = 5'd25,
    P_MO        = 5'd26,
    P_FUNC_DONE = 5'd30,
    P_MOD_DONE  = 5'd31
  } prog_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       last;
    kind_t      kind;
  } entry_t;

endpackage

[src/iesc_front.sv]
`timescale 1ns / 1ps
// Input side: takes characters and tags each with its character kind.
module iesc_front (
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              has_char,
  input  logic [7:0]        ch,
  input  logic              last,
  output logic              push_valid,
  input  logic              push_ready,
  output iesc_pkg::entry_t  push_entry
);

  function automatic iesc_pkg::kind_t classify(input logic [7:0] c);
    iesc_pkg::kind_t k;
    case (c) inside
      " ":            k = iesc_pkg::K_SPACE;
      "+", "-":       k = iesc_pkg::K_SIGN;
      "(":            k = iesc_pkg::K_OPEN;
      ")":            k = iesc_pkg::K_CLOSE;
      "*", "/":       k = iesc_pkg::K_MULDIV;
      "^":            k = iesc_pkg::K_POWER;
      ["0":"9"]:      k = iesc_pkg::K_DIGIT;
      ".":            k = iesc_pkg::K_DOT;
      "e", "E":       k = iesc_pkg::K_EXP;
      "m":            k = iesc_pkg::K_M;
      "a":            k = iesc_pkg::K_A;
      "s":            k = iesc_pkg::K_S;
      "c":            k = iesc_pkg::K_C;
      "t":            k = iesc_pkg::K_T;
      "l":            k = iesc_pkg::K_L;
      "x":            k = iesc_pkg::K_X;
      default:        k = iesc_pkg::K_OTHER;
    endcase
    return k;
  endfunction

  assign item_ready = push_ready;
  assign push_valid = item_valid;

  always_comb begin
    push_entry.has_char = has_char;
    push_entry.ch       = ch;
    push_entry.last     = last;
    push_entry.kind     = classify(ch);
  end

endmodule

[src/iesc_queue.sv]
`timescale 1ns / 1ps
// Short queue between the character front end and the checking back end.
module iesc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  iesc_pkg::entry_t  push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output iesc_pkg::entry_t  pop_entry
);

  localparam int Depth = iesc_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  iesc_pkg::entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/iesc_back.sv]
`timescale 1ns / 1ps
// Checking side: token state update, end-of-expression checks and result register.
module iesc_back #(
  parameter int MAX_LENGTH = iesc_pkg::MaxLength
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  iesc_pkg::entry_t  pop_entry,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              valid_res,
  output logic              uses_x
);

  localparam int CountW = $clog2(MAX_LENGTH + 2);
  localparam int DepthW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH + 1) : 1;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LENGTH);

  function automatic iesc_pkg::prog_t word_next(input iesc_pkg::prog_t p,
                                                input logic [7:0] c);
    iesc_pkg::prog_t n;
    n = iesc_pkg::P_NONE;
    case (p)
      iesc_pkg::P_A: begin
        if (c == "c") n = iesc_pkg::P_AC;
        else if (c == "s") n = iesc_pkg::P_AS;
        else if (c == "t") n = iesc_pkg::P_AT;
      end
      iesc_pkg::P_AC:  if (c == "o") n = iesc_pkg::P_ACO;
      iesc_pkg::P_ACO: if (c == "s") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_AS:  if (c == "i") n = iesc_pkg::P_ASI;
      iesc_pkg::P_ASI: if (c == "n") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_AT:  if (c == "a") n = iesc_pkg::P_ATA;
      iesc_pkg::P_ATA: if (c == "n") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_S: begin
        if (c == "i") n = iesc_pkg::P_SI;
        else if (c == "q") n = iesc_pkg::P_SQ;
      end
      iesc_pkg::P_SI:  if (c == "n") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_SQ:  if (c == "r") n = iesc_pkg::P_SQR;
      iesc_pkg::P_SQR: if (c == "t") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_C:   if (c == "o") n = iesc_pkg::P_CO;
      iesc_pkg::P_CO:  if (c == "s") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_T:   if (c == "a") n = iesc_pkg::P_TA;
      iesc_pkg::P_TA:  if (c == "n") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_L: begin
        if (c == "n") n = iesc_pkg::P_FUNC_DONE;
        else if (c == "o") n = iesc_pkg::P_LO;
      end
      iesc_pkg::P_LO:  if (c == "g") n = iesc_pkg::P_FUNC_DONE;
      iesc_pkg::P_M:   if (c == "o") n = iesc_pkg::P_MO;
      iesc_pkg::P_MO:  if (c == "d") n = iesc_pkg::P_MOD_DONE;
      default:         n = iesc_pkg::P_NONE;
    endcase
    return n;
  endfunction

  iesc_pkg::class_t last_class, last_class_next;
  iesc_pkg::prog_t  token_progress, token_progress_next;
  logic [DepthW-1:0] bracket_depth, bracket_depth_next;
  logic [CountW-1:0] char_count, char_count_next;
  logic failed, failed_next;
  logic x_seen, x_seen_next;

  logic pop;
  logic absorbed;
  logic start;
  iesc_pkg::class_t base_class;
  iesc_pkg::prog_t  word_to;
  iesc_pkg::kind_t  kind;
  logic end_failed;
  iesc_pkg::class_t end_class;
  logic too_long;
  logic ok;
  logic x_ok;

  assign pop_ready = !pop_entry.last || !result_valid || result_ready;
  assign pop       = pop_valid && pop_ready;
  assign kind      = pop_entry.kind;
  assign word_to   = word_next(token_progress, pop_entry.ch);

  always_comb begin
    last_class_next     = last_class;
    token_progress_next = token_progress;
    bracket_depth_next  = bracket_depth;
    char_count_next     = char_count;
    failed_next         = failed;
    x_seen_next         = x_seen;
    absorbed            = 1'b0;
    start               = 1'b0;
    base_class          = last_class;
    end_failed          = 1'b0;
    end_class           = last_class;
    too_long            = 1'b0;
    ok                  = 1'b0;
    x_ok                = 1'b0;

    if (pop && pop_entry.has_char) begin
      if (char_count <= MaxCount) begin
        char_count_next = char_count + 1'b1;
      end
      if (char_count_next > MaxCount) begin
        failed_next = 1'b1;
      end
      if (!failed_next) begin
        if (token_progress >= iesc_pkg::P_INT && token_progress <= iesc_pkg::P_EXP) begin
          case (token_progress)
            iesc_pkg::P_INT: begin
              absorbed = 1'b1;
              if (kind == iesc_pkg::K_DOT) token_progress_next = iesc_pkg::P_FRAC;
              else if (kind == iesc_pkg::K_EXP) token_progress_next = iesc_pkg::P_E;
              else if (kind != iesc_pkg::K_DIGIT) absorbed = 1'b0;
            end
            iesc_pkg::P_DOT0: begin
              absorbed = 1'b1;
              if (kind == iesc_pkg::K_DIGIT) token_progress_next = iesc_pkg::P_FRAC;
              else failed_next = 1'b1;
            end
            iesc_pkg::P_FRAC: begin
              absorbed = 1'b1;
              if (kind == iesc_pkg::K_EXP) token_progress_next = iesc_pkg::P_E;
              else if (kind != iesc_pkg::K_DIGIT) absorbed = 1'b0;
            end
            iesc_pkg::P_E: begin
              absorbed = 1'b1;
              if (kind == iesc_pkg::K_DIGIT) token_progress_next = iesc_pkg::P_EXP;
              else if (kind == iesc_pkg::K_SIGN) token_progress_next = iesc_pkg::P_ESIGN;
              else failed_next = 1'b1;
            end
            iesc_pkg::P_ESIGN: begin
              absorbed = 1'b1;
              if (kind == iesc_pkg::K_DIGIT) token_progress_next = iesc_pkg::P_EXP;
              else failed_next = 1'b1;
            end
            default: absorbed = (kind == iesc_pkg::K_DIGIT);
          endcase
          if (!absorbed) begin
            // The character that ends a number starts the next token.
            token_progress_next = iesc_pkg::P_NONE;
            last_class_next     = iesc_pkg::CLS_OPERAND;
            base_class          = iesc_pkg::CLS_OPERAND;
            start               = 1'b1;
          end
        end else if (token_progress >= iesc_pkg::P_A) begin
          if (word_to == iesc_pkg::P_NONE) begin
            failed_next = 1'b1;
          end else if (word_to == iesc_pkg::P_FUNC_DONE) begin
            last_class_next     = iesc_pkg::CLS_FUNC;
            token_progress_next = iesc_pkg::P_NONE;
          end else if (word_to == iesc_pkg::P_MOD_DONE) begin
            last_class_next     = iesc_pkg::CLS_MOD;
            token_progress_next = iesc_pkg::P_NONE;
          end else begin
            token_progress_next = word_to;
          end
        end else begin
          start = 1'b1;
        end

        if (start) begin
          case (kind)
            iesc_pkg::K_SPACE: ;
            iesc_pkg::K_SIGN: begin
              if (iesc_pkg::SignOkSet[base_class]) last_class_next = iesc_pkg::CLS_SIGN;
              else failed_next = 1'b1;
            end
            iesc_pkg::K_OPEN: begin
              if (iesc_pkg::OpenOkSet[base_class]) begin
                last_class_next    = iesc_pkg::CLS_OPEN;
                bracket_depth_next = bracket_depth + 1'b1;
              end else begin
                failed_next = 1'b1;
              end
            end
            iesc_pkg::K_CLOSE, iesc_pkg::K_MULDIV, iesc_pkg::K_POWER: begin
              if (!iesc_pkg::AfterOperandSet[base_class]) begin
                failed_next = 1'b1;
              end else if (kind == iesc_pkg::K_CLOSE) begin
                if (bracket_depth == '0) begin
                  failed_next = 1'b1;
                end else begin
                  bracket_depth_next = bracket_depth - 1'b1;
                  last_class_next    = iesc_pkg::CLS_CLOSE;
                end
              end else if (kind == iesc_pkg::K_POWER) begin
                last_class_next = iesc_pkg::CLS_POWER;
              end else begin
                last_class_next = iesc_pkg::CLS_MULDIV;
              end
            end
            iesc_pkg::K_M: begin
              if (iesc_pkg::AfterOperandSet[base_class]) token_progress_next = iesc_pkg::P_M;
              else failed_next = 1'b1;
            end
            default: begin
              if (!iesc_pkg::OperandOkSet[base_class]) begin
                failed_next = 1'b1;
              end else begin
                case (kind)
                  iesc_pkg::K_A: token_progress_next = iesc_pkg::P_A;
                  iesc_pkg::K_S: token_progress_next = iesc_pkg::P_S;
                  iesc_pkg::K_C: token_progress_next = iesc_pkg::P_C;
                  iesc_pkg::K_T: token_progress_next = iesc_pkg::P_T;
                  iesc_pkg::K_L: token_progress_next = iesc_pkg::P_L;
                  iesc_pkg::K_X: begin
                    last_class_next = iesc_pkg::CLS_OPERAND;
                    x_seen_next     = 1'b1;
                  end
                  iesc_pkg::K_DIGIT: begin
                    token_progress_next = iesc_pkg::P_INT;
                    last_class_next     = iesc_pkg::CLS_OPERAND;
                  end
                  iesc_pkg::K_DOT: begin
                    token_progress_next = iesc_pkg::P_DOT0;
                    last_class_next     = iesc_pkg::CLS_OPERAND;
                  end
                  default: failed_next = 1'b1;
                endcase
              end
            end
          endcase
        end
      end
    end

    if (pop && pop_entry.last) begin
      end_failed = failed_next;
      end_class  = last_class_next;
      if (!failed_next && token_progress_next != iesc_pkg::P_NONE) begin
        if (token_progress_next == iesc_pkg::P_INT || token_progress_next == iesc_pkg::P_FRAC ||
            token_progress_next == iesc_pkg::P_EXP) begin
          end_class = iesc_pkg::CLS_OPERAND;
        end else begin
          end_failed = 1'b1;
        end
      end
      too_long = (char_count_next > MaxCount);
      ok   = !end_failed && (char_count_next != '0) && !too_long &&
             (bracket_depth_next == '0) && !iesc_pkg::EndBadSet[end_class];
      x_ok = x_seen_next && (char_count_next != '0) && !too_long;

      last_class_next     = iesc_pkg::CLS_START;
      token_progress_next = iesc_pkg::P_NONE;
      bracket_depth_next  = '0;
      char_count_next     = '0;
      failed_next         = 1'b0;
      x_seen_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_class     <= iesc_pkg::CLS_START;
      token_progress <= iesc_pkg::P_NONE;
      bracket_depth  <= '0;
      char_count     <= '0;
      failed         <= 1'b0;
      x_seen         <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      last_class     <= last_class_next;
      token_progress <= token_progress_next;
      bracket_depth  <= bracket_depth_next;
      char_count     <= char_count_next;
      failed         <= failed_next;
      x_seen         <= x_seen_next;
      if (pop && pop_entry.last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_entry.last) begin
      valid_res <= ok;
      uses_x    <= x_ok;
    end
  end

endmodule

[src/infix_expression_syntax_checker_unit.sv]
`timescale 1ns / 1ps
// Top level of the infix expression syntax checker.
//
// The block checks one arithmetic expression given as a stream of characters,
// one per transfer, and returns one result on the transfer marked last. It takes
// one character every clock cycle while the queue has room: the front end tags
// each character with its kind and writes it into a two-entry queue, and the
// back end reads one entry per cycle unless it holds a last character, and
// updates the token state. A result is registered in the output register when
// the back end reads its last character from the queue, and a new expression
// may follow at once. The back end holds a last character in the queue only
// while an earlier result still waits in the output register.
module infix_expression_syntax_checker_unit #(
  parameter int MAX_LENGTH = iesc_pkg::MaxLength
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       has_char,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       valid_res,
  output logic       uses_x
);

  logic             push_valid;
  logic             push_ready;
  iesc_pkg::entry_t push_entry;
  logic             q_valid;
  logic             q_ready;
  iesc_pkg::entry_t q_entry;

  iesc_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .has_char   (has_char),
    .ch         (ch),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  iesc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  iesc_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (q_valid),
    .pop_ready    (q_ready),
    .pop_entry    (q_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res),
    .uses_x       (uses_x)
  );

  a_empty_queue_ready: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> item_ready)
    else $error("Input not ready while the queue is empty.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_entry.last) |=> result_valid)
    else $error("No result after the last character of an expression.");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(q_valid && q_ready && q_entry.last))
    else $error("Result appeared without a last character.");

endmodule
